// ===== rtl/core/bfp_pkg.sv =====
// Shared types and constants for the beacon frame parser.
`default_nettype none
package bfp_pkg;

  // Frame layout
  localparam int MAGIC_BYTES = 4;
  localparam int MIN_FRAME   = MAGIC_BYTES + 4 + 4 + 8;
  localparam logic [4:0] TOTAL_MAX = 5'd31;

  // Result queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Result kinds
  localparam logic [1:0] KIND_NET     = 2'd0;
  localparam logic [1:0] KIND_NODE    = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // Parser phases
  typedef enum logic [7:0] {
    PH_MAGIC   = 8'b0000_0001,
    PH_NETLEN  = 8'b0000_0010,
    PH_NETID   = 8'b0000_0100,
    PH_NODELEN = 8'b0000_1000,
    PH_NODEID  = 8'b0001_0000,
    PH_STAMP   = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_TRAIL   = 8'b1000_0000
  } bfp_phase_t;

  // Verdict status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_NET_OVR  = 3'd3,
    ST_NODE_OVR = 3'd4,
    ST_TRUNC    = 3'd5,
    ST_TRAIL    = 3'd6
  } bfp_status_t;

  // One queue entry: up to one id byte and one verdict caused by one input byte
  typedef struct packed {
    logic        has_id;
    logic [1:0]  id_kind;
    logic [7:0]  id_byte;
    logic        has_verdict;
    bfp_status_t status;
    logic [63:0] stamp;
    logic [31:0] network_len;
    logic [31:0] node_len;
  } bfp_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic valid;
  } bfp_qstat_t;

  // One result item
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  data_byte;
    logic        last_of_run;
    logic [2:0]  status;
    logic [63:0] stamp;
    logic [31:0] network_len;
    logic [31:0] node_len;
  } bfp_result_t;

endpackage
`default_nettype wire

// ===== rtl/core/bfp_front.sv =====
// Front part: accepts frame bytes, tracks the parse state, queues results.
`default_nettype none
module bfp_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  input  wire logic [63:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_byte,
  input  wire logic                in_end,
  input  wire bfp_pkg::bfp_qstat_t qstat,
  output logic                     push,
  output bfp_pkg::bfp_entry_t      push_entry
);
  import bfp_pkg::*;

  logic [63:0] magic_value;
  bfp_phase_t  phase, phase_next;
  logic [31:0] field_count, field_count_next;
  logic [31:0] length_shift, length_shift_next;
  logic [31:0] network_len_hold, network_len_hold_next;
  logic [31:0] node_len_hold, node_len_hold_next;
  logic [63:0] stamp_shift, stamp_shift_next;
  logic [4:0]  total_count, total_count_next;
  logic        magic_bad, magic_bad_next;
  logic [31:0] fc_inc;
  logic        accept;
  logic        id_hit;
  logic [1:0]  id_kind;
  bfp_status_t status;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign fc_inc   = field_count + 32'd1;

  // Advance the parse state for one byte
  always_comb begin
    phase_next            = phase;
    field_count_next      = field_count;
    length_shift_next     = length_shift;
    network_len_hold_next = network_len_hold;
    node_len_hold_next    = node_len_hold;
    stamp_shift_next      = stamp_shift;
    magic_bad_next        = magic_bad;
    total_count_next      = (total_count < TOTAL_MAX) ? total_count + 5'd1 : total_count;
    id_hit                = 1'b0;
    id_kind               = KIND_NET;
    case (phase)
      PH_MAGIC: begin
        if (in_byte != magic_value[{field_count[2:0], 3'b000} +: 8]) begin
          magic_bad_next = 1'b1;
        end
        field_count_next = fc_inc;
        if (fc_inc >= 32'(MAGIC_BYTES)) begin
          field_count_next = '0;
          phase_next       = PH_NETLEN;
        end
      end
      PH_NETLEN, PH_NODELEN: begin
        length_shift_next[{field_count[1:0], 3'b000} +: 8] =
          length_shift[{field_count[1:0], 3'b000} +: 8] | in_byte;
        field_count_next = fc_inc;
        if (fc_inc >= 32'd4) begin
          if (phase == PH_NETLEN) begin
            network_len_hold_next = length_shift_next;
          end else begin
            node_len_hold_next = length_shift_next;
          end
          field_count_next  = length_shift_next;
          length_shift_next = '0;
          if (field_count_next != '0) begin
            phase_next = (phase == PH_NETLEN) ? PH_NETID : PH_NODEID;
          end else begin
            // zero length: skip the id field
            phase_next = (phase == PH_NETLEN) ? PH_NODELEN : PH_STAMP;
          end
        end
      end
      PH_NETID, PH_NODEID: begin
        id_hit           = 1'b1;
        id_kind          = (phase == PH_NETID) ? KIND_NET : KIND_NODE;
        field_count_next = field_count - 32'd1;
        if (field_count_next == '0) begin
          phase_next = (phase == PH_NETID) ? PH_NODELEN : PH_STAMP;
        end
      end
      PH_STAMP: begin
        stamp_shift_next[{field_count[2:0], 3'b000} +: 8] =
          stamp_shift[{field_count[2:0], 3'b000} +: 8] | in_byte;
        field_count_next = fc_inc;
        if (fc_inc >= 32'd8) begin
          field_count_next = '0;
          phase_next       = PH_DONE;
        end
      end
      default: begin
        // past the timestamp: count, forward nothing
        phase_next = PH_TRAIL;
      end
    endcase
  end

  // Pick the verdict from how far the parse got
  always_comb begin
    if (total_count_next < 5'(MIN_FRAME)) begin
      status = ST_SHORT;
    end else if (magic_bad_next) begin
      status = ST_MAGIC;
    end else begin
      case (phase_next)
        PH_NETID:  status = ST_NET_OVR;
        PH_NODEID: status = ST_NODE_OVR;
        PH_DONE:   status = ST_OK;
        PH_TRAIL:  status = ST_TRAIL;
        default:   status = ST_TRUNC;
      endcase
    end
  end

  // Build the queue entry
  always_comb begin
    push                   = accept && (id_hit || in_end);
    push_entry.has_id      = id_hit;
    push_entry.id_kind     = id_kind;
    push_entry.id_byte     = in_byte;
    push_entry.has_verdict = in_end;
    push_entry.status      = status;
    push_entry.stamp       = (status == ST_OK) ? stamp_shift_next : '0;
    push_entry.network_len = network_len_hold_next;
    push_entry.node_len    = node_len_hold_next;
  end

  // Hold the prefix register
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value <= '0;
    end else if (cfg_valid) begin
      magic_value <= cfg_data;
    end
  end

  // Update the parse state; clear it after a verdict
  always_ff @(posedge clk) begin
    if (rst || (accept && in_end)) begin
      phase            <= PH_MAGIC;
      field_count      <= '0;
      length_shift     <= '0;
      network_len_hold <= '0;
      node_len_hold    <= '0;
      stamp_shift      <= '0;
      total_count      <= '0;
      magic_bad        <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      field_count      <= field_count_next;
      length_shift     <= length_shift_next;
      network_len_hold <= network_len_hold_next;
      node_len_hold    <= node_len_hold_next;
      stamp_shift      <= stamp_shift_next;
      total_count      <= total_count_next;
      magic_bad        <= magic_bad_next;
    end
  end

  a_clear_after_verdict: assert property (@(posedge clk) disable iff (rst)
    (accept && in_end) |=> (phase == PH_MAGIC && total_count == '0 && !magic_bad))
    else $error("parse state not cleared after verdict");

  a_ok_needs_clean_magic: assert property (@(posedge clk) disable iff (rst)
    (push && push_entry.has_verdict && push_entry.status == ST_OK)
      |-> (!magic_bad_next && total_count_next >= 5'(MIN_FRAME)))
    else $error("ok verdict on bad prefix or short frame");

endmodule
`default_nettype wire

// ===== rtl/core/bfp_queue.sv =====
// Short result queue that decouples the parser from the output side.
`default_nettype none
module bfp_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire bfp_pkg::bfp_entry_t push_entry,
  input  wire logic                pop,
  output bfp_pkg::bfp_entry_t      head,
  output bfp_pkg::bfp_qstat_t      qstat
);
  import bfp_pkg::*;

  bfp_entry_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head        = mem[rd_ptr];
  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.valid = (count != '0);

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !qstat.valid |-> !pop)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/core/bfp_back.sv =====
// Back part: drains queue entries into one result register.
`default_nettype none
module bfp_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bfp_pkg::bfp_entry_t head,
  input  wire bfp_pkg::bfp_qstat_t qstat,
  output logic                     pop,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output bfp_pkg::bfp_result_t     res
);
  import bfp_pkg::*;

  logic        sub, sub_next;
  logic        load;
  bfp_result_t res_next;

  assign load = !res_valid || res_ready;

  // Select the next result: id byte first, then the verdict of the same entry
  always_comb begin
    pop      = 1'b0;
    sub_next = sub;
    res_next = res;
    if (load && qstat.valid) begin
      if (head.has_id && !sub) begin
        res_next.item_kind   = head.id_kind;
        res_next.data_byte   = head.id_byte;
        res_next.last_of_run = !head.has_verdict;
        res_next.status      = ST_OK;
        res_next.stamp       = '0;
        res_next.network_len = '0;
        res_next.node_len    = '0;
        if (head.has_verdict) begin
          sub_next = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        res_next.item_kind   = KIND_VERDICT;
        res_next.data_byte   = '0;
        res_next.last_of_run = 1'b1;
        res_next.status      = head.status;
        res_next.stamp       = head.stamp;
        res_next.network_len = head.network_len;
        res_next.node_len    = head.node_len;
        pop                  = 1'b1;
        sub_next             = 1'b0;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

  // Track output valid and the split-entry flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sub       <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= qstat.valid;
      end
      sub <= sub_next;
    end
  end

  a_id_then_verdict: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res.item_kind != KIND_VERDICT && !res.last_of_run)
      |=> (res_valid && res.item_kind == KIND_VERDICT))
    else $error("verdict does not follow split id byte");

  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.item_kind == KIND_VERDICT) |-> res.last_of_run)
    else $error("verdict not marked last");

endmodule
`default_nettype wire

// ===== rtl/core/beacon_frame_parser_unit.sv =====
// Beacon frame parser: frame bytes in, tagged id bytes and a verdict out.
//
// Usage:
//   s_* carries one frame byte per transfer; s_tlast marks the frame's last byte.
//   m_* carries results: network id bytes (tuser 0), node id bytes (tuser 1) and
//   one verdict (tuser 2) on the last byte of each frame, with status, timestamp
//   and both declared lengths. m_tlast marks the final result of an input byte.
//   Discard the id bytes of a frame whose verdict status is not ok.
//   cfg_* writes the expected prefix (byte i in bits 8i+7..8i); write it only
//   while the block is idle. cfg_ready is always high.
// Timing:
//   One byte per cycle sustained while s_tready is high. Each result passes
//   through the result queue and then the result register before m_tvalid
//   rises. A last byte that is also an id byte gives two results, one after
//   the other; the four-entry result queue absorbs this, and s_tready drops
//   only when that queue is full.
// Reset clears the parse state, the queue and the prefix register (to zero).
// When the receiver stalls, the result is held and the queue fills, then
// s_tready goes low until results are taken.
`default_nettype none
module beacon_frame_parser_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [63:0]  cfg_data,   // magic_value
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,    // in_byte[7:0]
  input  wire logic         s_tlast,    // frame_end
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // data_byte[7:0], status[10:8], stamp[74:11], network_len[106:75],
  // node_len[138:107], zero[143:139]
  output logic [143:0]      m_tdata,
  output logic [1:0]        m_tuser,    // item_kind[1:0]
  output logic              m_tlast     // last_of_run
);
  import bfp_pkg::*;

  bfp_qstat_t  qstat;
  bfp_entry_t  push_entry, head;
  logic        push, pop;
  bfp_result_t res;

  assign cfg_ready = 1'b1;

  bfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_end     (s_tlast),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  bfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  bfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // Pack the result onto the master side
  assign m_tdata = {5'b0, res.node_len, res.network_len, res.stamp, res.status,
                    res.data_byte};
  assign m_tuser = res.item_kind;
  assign m_tlast = res.last_of_run;

endmodule
`default_nettype wire
